// ===== rtl/core/jmos_pkg.sv =====
// Package for the JPEG marker offset scanner: beat payload types, marker
// codes, configuration register indexes and the scan phase encoding.
// No dependencies.
package jmos_pkg;

	localparam int OUT_W = 24;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 1;

	// Marker codes seen after a 0xFF byte.
	localparam logic [7:0] MK_FF   = 8'hFF;
	localparam logic [7:0] MK_STUFF = 8'h00;
	localparam logic [7:0] MK_DHT  = 8'hC4;
	localparam logic [7:0] MK_DQT  = 8'hDB;
	localparam logic [7:0] MK_SOF0 = 8'hC0;
	localparam logic [7:0] MK_SOS  = 8'hDA;
	localparam logic [7:0] MK_EOI  = 8'hD9;
	localparam logic [7:0] MK_SOI  = 8'hD8;
	localparam logic [7:0] MK_APP1 = 8'hE1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT_NEXT = 1'd1;

	typedef enum logic [5:0] {
		PH_HUNT  = 6'b000001,
		PH_FILL  = 6'b000010,
		PH_LENHI = 6'b000100,
		PH_LENLO = 6'b001000,
		PH_SKIP  = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [OUT_W-1:0] field_length;
		logic [OUT_W-1:0] next_field_offset;
		logic [OUT_W-1:0] quant_table_offset;
		logic [OUT_W-1:0] huffman_table_offset;
		logic [OUT_W-1:0] frame_header_offset;
		logic [OUT_W-1:0] scan_header_offset;
		logic [OUT_W-1:0] entropy_data_offset;
		logic [OUT_W-1:0] app1_payload_offset;
	} out_beat_t;

endpackage

// ===== rtl/core/jmos_stream_if.sv =====
// Valid/ready stream interface used for the byte input and the header output.
// The payload type is a parameter; the scanner uses the beat types of jmos_pkg.
interface jmos_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/jpeg_marker_offset_scanner_top.sv =====
// Top level of the JPEG marker offset scanner.
// Depends on jmos_pkg and jmos_stream_if.
//
// Usage: the bytes of one compressed JPEG field arrive on byte_in, one byte
// per beat, with last_byte set on the final byte. The scanner follows the
// marker structure (fill bytes, stuffed zeros, segment lengths and skips) and
// records where the DQT, DHT, SOF0, SOS and APP1 segments sit. On the beat
// that carries last_byte it loads one header beat onto hdr_out with the field
// size, the next field offset and the recorded offsets, then starts over.
// Throughput is one byte per cycle: every byte is folded into the scan state
// by a single pass of logic between the state registers and the output
// register. The header beat is valid in the cycle after the last byte.
// The output register is the only buffer between the two sides: while a header
// beat is held and hdr_out.ready is low, byte_in.ready is low, so a stalled
// receiver stalls the byte stream; otherwise bytes are taken back to back.
// Reset clears the scan state, the recorded offsets and both configuration
// bits; no header beat is pending after reset.
// The configuration port (cfg_we, cfg_index, cfg_data) writes raw_length_mode
// (index 0) and report_next_offset (index 1); a write acts from the next byte.
module jpeg_marker_offset_scanner_top #(
	parameter int POS_WIDTH = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [jmos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jmos_pkg::CFG_DATA_W-1:0] cfg_data,
	jmos_stream_if.sink                      byte_in,
	jmos_stream_if.source                    hdr_out
);

	localparam int EXT_W = (POS_WIDTH > jmos_pkg::OUT_W) ? POS_WIDTH : jmos_pkg::OUT_W;

	// Positions are kept at POS_WIDTH bits and reported on 24 bits.
	function automatic logic [jmos_pkg::OUT_W-1:0] to_out(input logic [POS_WIDTH-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[jmos_pkg::OUT_W-1:0];
	endfunction

	// Configuration bits.
	logic raw_mode_q;
	logic report_next_q;

	// Scan state.
	jmos_pkg::phase_t     phase_q, phase_d;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] mark_pos_q, mark_pos_d;
	logic                 is_sos_q, is_sos_d;
	logic                 is_app1_q, is_app1_d;
	logic [7:0]           len_hi_q, len_hi_d;
	logic [15:0]          skip_q, skip_d;

	// Recorded offsets.
	logic [POS_WIDTH-1:0] quant_q, quant_d;
	logic [POS_WIDTH-1:0] huff_q, huff_d;
	logic [POS_WIDTH-1:0] frame_q, frame_d;
	logic [POS_WIDTH-1:0] scan_q, scan_d;
	logic [POS_WIDTH-1:0] data_q, data_d;
	logic [POS_WIDTH-1:0] app1_q, app1_d;

	// Output register.
	logic                 out_valid_q;
	jmos_pkg::out_beat_t  out_data_q;

	logic                 accept;
	logic [7:0]           b;
	logic                 last;
	logic [POS_WIDTH-1:0] pos_next;
	logic [POS_WIDTH-1:0] ff_pos;
	logic [POS_WIDTH-1:0] data_bias;
	logic [15:0]          seg_len;

	assign byte_in.ready = !out_valid_q || hdr_out.ready;
	assign accept        = byte_in.valid && byte_in.ready;
	assign b             = byte_in.data.data_byte;
	assign last          = byte_in.data.last_byte;
	assign pos_next      = pos_q + POS_WIDTH'(1);
	assign ff_pos        = pos_q - POS_WIDTH'(1);
	assign data_bias     = raw_mode_q ? POS_WIDTH'(3) : POS_WIDTH'(1);
	assign seg_len       = {len_hi_q, b};

	// One pass of the scan for the byte on byte_in.
	always_comb begin
		phase_d   = phase_q;
		mark_pos_d = mark_pos_q;
		is_sos_d  = is_sos_q;
		is_app1_d = is_app1_q;
		len_hi_d  = len_hi_q;
		skip_d    = skip_q;
		quant_d   = quant_q;
		huff_d    = huff_q;
		frame_d   = frame_q;
		scan_d    = scan_q;
		data_d    = data_q;
		app1_d    = app1_q;
		unique case (phase_q)
			jmos_pkg::PH_HUNT: begin
				if (b == jmos_pkg::MK_FF) begin
					phase_d = jmos_pkg::PH_FILL;
				end
			end
			jmos_pkg::PH_FILL: begin
				if (b == jmos_pkg::MK_STUFF) begin
					phase_d = jmos_pkg::PH_HUNT;
				end else if (b != jmos_pkg::MK_FF) begin
					mark_pos_d = pos_q;
					is_sos_d   = (b == jmos_pkg::MK_SOS);
					is_app1_d  = (b == jmos_pkg::MK_APP1);
					case (b)
						jmos_pkg::MK_DHT: begin
							huff_d  = ff_pos;
							phase_d = jmos_pkg::PH_LENHI;
						end
						jmos_pkg::MK_DQT: begin
							quant_d = ff_pos;
							phase_d = jmos_pkg::PH_LENHI;
						end
						jmos_pkg::MK_SOF0: begin
							frame_d = ff_pos;
							phase_d = jmos_pkg::PH_LENHI;
						end
						jmos_pkg::MK_SOS: begin
							scan_d  = ff_pos;
							data_d  = pos_q + data_bias;
							phase_d = jmos_pkg::PH_LENHI;
						end
						jmos_pkg::MK_APP1: begin
							app1_d  = pos_q + POS_WIDTH'(3);
							phase_d = jmos_pkg::PH_LENHI;
						end
						jmos_pkg::MK_EOI: begin
							phase_d = jmos_pkg::PH_DONE;
						end
						default: begin
							// SOI and unlisted markers carry no segment here.
							phase_d = jmos_pkg::PH_HUNT;
						end
					endcase
				end
			end
			jmos_pkg::PH_LENHI: begin
				len_hi_d = b;
				phase_d  = jmos_pkg::PH_LENLO;
			end
			jmos_pkg::PH_LENLO: begin
				if (is_sos_q) begin
					data_d  = mark_pos_q + POS_WIDTH'(seg_len) + data_bias;
					phase_d = jmos_pkg::PH_DONE;
				end else begin
					if (!is_app1_q && raw_mode_q) begin
						skip_d = seg_len;
					end else if (seg_len >= 16'd2) begin
						skip_d = seg_len - 16'd2;
					end else begin
						skip_d = '0;
					end
					phase_d = (skip_d != '0) ? jmos_pkg::PH_SKIP : jmos_pkg::PH_HUNT;
				end
			end
			jmos_pkg::PH_SKIP: begin
				// The count is never zero in this phase.
				skip_d = skip_q - 16'd1;
				if (skip_q == 16'd1) begin
					phase_d = jmos_pkg::PH_HUNT;
				end
			end
			jmos_pkg::PH_DONE: begin
				// Scan ended: bytes are counted until the last one.
			end
			default: begin
				phase_d = jmos_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q    <= 1'b0;
			report_next_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jmos_pkg::CFG_RAW_LENGTH:  raw_mode_q    <= cfg_data[0];
				jmos_pkg::CFG_REPORT_NEXT: report_next_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= jmos_pkg::PH_HUNT;
			pos_q      <= '0;
			mark_pos_q <= '0;
			is_sos_q   <= 1'b0;
			is_app1_q  <= 1'b0;
			len_hi_q   <= '0;
			skip_q     <= '0;
			quant_q    <= '0;
			huff_q     <= '0;
			frame_q    <= '0;
			scan_q     <= '0;
			data_q     <= '0;
			app1_q     <= '0;
		end else if (accept) begin
			if (last) begin
				// The field is closed: start the next one from a clean state.
				phase_q    <= jmos_pkg::PH_HUNT;
				pos_q      <= '0;
				mark_pos_q <= '0;
				is_sos_q   <= 1'b0;
				is_app1_q  <= 1'b0;
				len_hi_q   <= '0;
				skip_q     <= '0;
				quant_q    <= '0;
				huff_q     <= '0;
				frame_q    <= '0;
				scan_q     <= '0;
				data_q     <= '0;
				app1_q     <= '0;
			end else begin
				phase_q    <= phase_d;
				pos_q      <= pos_next;
				mark_pos_q <= mark_pos_d;
				is_sos_q   <= is_sos_d;
				is_app1_q  <= is_app1_d;
				len_hi_q   <= len_hi_d;
				skip_q     <= skip_d;
				quant_q    <= quant_d;
				huff_q     <= huff_d;
				frame_q    <= frame_d;
				scan_q     <= scan_d;
				data_q     <= data_d;
				app1_q     <= app1_d;
			end
		end
	end

	// Header beat register: loaded by the last byte, released by hdr_out.ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (hdr_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			out_data_q.field_length         <= to_out(pos_next);
			out_data_q.next_field_offset    <= report_next_q ? to_out(pos_next) : '0;
			out_data_q.quant_table_offset   <= to_out(quant_d);
			out_data_q.huffman_table_offset <= to_out(huff_d);
			out_data_q.frame_header_offset  <= to_out(frame_d);
			out_data_q.scan_header_offset   <= to_out(scan_d);
			out_data_q.entropy_data_offset  <= to_out(data_d);
			out_data_q.app1_payload_offset  <= to_out(app1_d);
		end
	end

	assign hdr_out.valid = out_valid_q;
	assign hdr_out.data  = out_data_q;

	// A byte is never taken while a header beat is held up downstream.
	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && out_valid_q && !hdr_out.ready))
		else $error("byte accepted while header beat is stalled");

	// The last byte produces a header beat and restarts the position count.
	a_last_closes_field: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (hdr_out.valid && pos_q == '0 && phase_q == jmos_pkg::PH_HUNT))
		else $error("last byte did not close the field");

	// A segment skip always has bytes left to consume.
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jmos_pkg::PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with zero count");

	// The SOS length ends the scan.
	a_sos_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last && phase_q == jmos_pkg::PH_LENLO && is_sos_q)
		|=> (phase_q == jmos_pkg::PH_DONE))
		else $error("SOS length did not end the scan");

endmodule

// ===== verif/jmos_offset_checker.sv =====
// Checker for the JPEG marker offset scanner: follows the byte and header channels,
// predicts each header beat from the accepted bytes and compares it field by field.
// Depends on jmos_pkg.
module jmos_offset_checker #(
	parameter int POS_WIDTH = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [jmos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jmos_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             byte_valid,
	input  logic                             byte_ready,
	input  jmos_pkg::in_beat_t               byte_data,
	input  logic                             hdr_valid,
	input  logic                             hdr_ready,
	input  jmos_pkg::out_beat_t              hdr_data,
	output int                               mismatches,
	output int                               pending,
	output int                               headers_checked
);

	localparam int SLOT_QUANT = 0;
	localparam int SLOT_HUFF  = 1;
	localparam int SLOT_FRAME = 2;
	localparam int SLOT_SCAN  = 3;
	localparam int SLOT_DATA  = 4;
	localparam int SLOT_APP1  = 5;
	localparam int N_FIELDS   = 8;

	logic                 raw_len;
	logic                 report_next;
	logic [POS_WIDTH-1:0] pos;
	logic [POS_WIDTH-1:0] mark_pos;
	jmos_pkg::phase_t     phase;
	logic [7:0]           marker;
	logic [7:0]           len_hi;
	logic [16:0]          skip_left;
	logic [POS_WIDTH-1:0] slots [6];
	jmos_pkg::out_beat_t  expected_headers[$];
	string                field_names [N_FIELDS] = '{"field_length", "next_field_offset",
		"quant_table_offset", "huffman_table_offset", "frame_header_offset",
		"scan_header_offset", "entropy_data_offset", "app1_payload_offset"};

	function automatic void restart_scan();
		pos = '0;
		mark_pos = '0;
		phase = jmos_pkg::PH_HUNT;
		marker = '0;
		len_hi = '0;
		skip_left = '0;
		for (int i = 0; i < 6; i++) slots[i] = '0;
	endfunction

	function automatic void enter_marker(input logic [7:0] m, input logic [POS_WIDTH-1:0] p);
		logic [POS_WIDTH-1:0] ff_pos;
		ff_pos = p - 1'b1;
		marker = m;
		mark_pos = p;
		phase = jmos_pkg::PH_LENHI;
		case (m)
			jmos_pkg::MK_DHT: slots[SLOT_HUFF] = ff_pos;
			jmos_pkg::MK_DQT: slots[SLOT_QUANT] = ff_pos;
			jmos_pkg::MK_SOF0: slots[SLOT_FRAME] = ff_pos;
			jmos_pkg::MK_SOS: begin
				slots[SLOT_SCAN] = ff_pos;
				slots[SLOT_DATA] = p + POS_WIDTH'(raw_len ? 3 : 1);
			end
			jmos_pkg::MK_APP1: slots[SLOT_APP1] = p + POS_WIDTH'(3);
			jmos_pkg::MK_EOI: phase = jmos_pkg::PH_DONE;
			default: phase = jmos_pkg::PH_HUNT;
		endcase
	endfunction

	function automatic void take_length(input logic [15:0] len);
		logic [16:0] skip;
		if (marker == jmos_pkg::MK_SOS) begin
			// The entropy data starts right after the SOS header; the scan ends here.
			slots[SLOT_DATA] = mark_pos + POS_WIDTH'(len) + POS_WIDTH'(raw_len ? 3 : 1);
			phase = jmos_pkg::PH_DONE;
		end else begin
			if (marker != jmos_pkg::MK_APP1 && raw_len)
				skip = {1'b0, len};
			else
				skip = (len >= 16'd2) ? {1'b0, len - 16'd2} : 17'd0;
			skip_left = skip;
			phase = (skip != 0) ? jmos_pkg::PH_SKIP : jmos_pkg::PH_HUNT;
		end
	endfunction

	function automatic void fold_scan_byte(input jmos_pkg::in_beat_t beat);
		logic [7:0]           b;
		logic [POS_WIDTH-1:0] p;
		jmos_pkg::out_beat_t  hdr;
		b = beat.data_byte;
		p = pos;
		case (phase)
			jmos_pkg::PH_HUNT: if (b == jmos_pkg::MK_FF) phase = jmos_pkg::PH_FILL;
			jmos_pkg::PH_FILL: begin
				if (b == jmos_pkg::MK_STUFF)
					phase = jmos_pkg::PH_HUNT;
				else if (b != jmos_pkg::MK_FF)
					enter_marker(b, p);
			end
			jmos_pkg::PH_LENHI: begin
				len_hi = b;
				phase = jmos_pkg::PH_LENLO;
			end
			jmos_pkg::PH_LENLO: take_length({len_hi, b});
			jmos_pkg::PH_SKIP: begin
				if (skip_left != 0) skip_left = skip_left - 1'b1;
				if (skip_left == 0) phase = jmos_pkg::PH_HUNT;
			end
			default: ;
		endcase
		pos = p + 1'b1;
		if (beat.last_byte) begin
			hdr.field_length         = jmos_pkg::OUT_W'(pos);
			hdr.next_field_offset    = report_next ? jmos_pkg::OUT_W'(pos) : '0;
			hdr.quant_table_offset   = jmos_pkg::OUT_W'(slots[SLOT_QUANT]);
			hdr.huffman_table_offset = jmos_pkg::OUT_W'(slots[SLOT_HUFF]);
			hdr.frame_header_offset  = jmos_pkg::OUT_W'(slots[SLOT_FRAME]);
			hdr.scan_header_offset   = jmos_pkg::OUT_W'(slots[SLOT_SCAN]);
			hdr.entropy_data_offset  = jmos_pkg::OUT_W'(slots[SLOT_DATA]);
			hdr.app1_payload_offset  = jmos_pkg::OUT_W'(slots[SLOT_APP1]);
			expected_headers.push_back(hdr);
			restart_scan();
		end
	endfunction

	function automatic void compare_header(input jmos_pkg::out_beat_t got);
		jmos_pkg::out_beat_t        want;
		logic [jmos_pkg::OUT_W-1:0] w;
		logic [jmos_pkg::OUT_W-1:0] g;
		if (expected_headers.size() == 0) begin
			$display("%0t: header beat with no bytes to account for it: %h", $time, got);
			mismatches++;
		end else begin
			want = expected_headers.pop_front();
			for (int k = 0; k < N_FIELDS; k++) begin
				w = want[(N_FIELDS-1-k)*jmos_pkg::OUT_W +: jmos_pkg::OUT_W];
				g = got[(N_FIELDS-1-k)*jmos_pkg::OUT_W +: jmos_pkg::OUT_W];
				if (w !== g) begin
					$display("%0t: %s mismatch: expected 0x%06h, actual 0x%06h",
						$time, field_names[k], w, g);
					mismatches++;
				end
			end
		end
		headers_checked++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_len = 1'b0;
			report_next = 1'b0;
			restart_scan();
			expected_headers.delete();
			mismatches = 0;
			headers_checked = 0;
		end else begin
			// A byte accepted at the same edge as a register write still uses the old setting.
			if (byte_valid && byte_ready) fold_scan_byte(byte_data);
			if (cfg_we) begin
				case (cfg_index)
					jmos_pkg::CFG_RAW_LENGTH: raw_len = cfg_data[0];
					jmos_pkg::CFG_REPORT_NEXT: report_next = cfg_data[0];
					default: ;
				endcase
			end
			if (hdr_valid && hdr_ready) compare_header(hdr_data);
		end
		pending = expected_headers.size();
	end
endmodule

// ===== verif/tb_jpeg_marker_offset_scanner_top.sv =====
// Testbench top for the JPEG marker offset scanner: drives byte fields and the
// configuration port, throttles the header channel and gives the verdict.
// Depends on jmos_pkg, jmos_stream_if, the scanner RTL and jmos_offset_checker.
module tb_jpeg_marker_offset_scanner_top;

	localparam int POS_WIDTH      = 24;
	// Cycles without any beat on either channel before the run is declared hung.
	localparam int QUIET_LIMIT    = 1000;
	localparam int SEGMENTS       = 8;
	localparam int SEG_MIN_BYTES  = 45;
	localparam int SEG_MIN_FIELDS = 3;
	localparam int BIG_SKIP_LEN   = 48;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [jmos_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [jmos_pkg::CFG_DATA_W-1:0] cfg_data;

	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         bytes_sent = 0;
	int         fields_sent = 0;
	int         quiet_cycles = 0;
	int         mismatches;
	int         pending;
	int         headers_checked;
	logic       mode_raw;
	logic [7:0] field_bytes[$];

	jmos_stream_if #(.T(jmos_pkg::in_beat_t))  byte_if ();
	jmos_stream_if #(.T(jmos_pkg::out_beat_t)) hdr_if ();

	jpeg_marker_offset_scanner_top #(
		.POS_WIDTH(POS_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_in(byte_if),
		.hdr_out(hdr_if)
	);

	jmos_offset_checker #(
		.POS_WIDTH(POS_WIDTH)
	) offset_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_if.valid),
		.byte_ready(byte_if.ready),
		.byte_data(byte_if.data),
		.hdr_valid(hdr_if.valid),
		.hdr_ready(hdr_if.ready),
		.hdr_data(hdr_if.data),
		.mismatches(mismatches),
		.pending(pending),
		.headers_checked(headers_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The header sink stalls at random with the current stall rate. It changes only
	// at falling edges so that the DUT and the checker see a settled value.
	initial begin
		hdr_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			hdr_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any accepted beat on either channel counts as progress. A hang,
	// including a header that never arrives, ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (byte_if.valid && byte_if.ready) || (hdr_if.valid && hdr_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired after %0d cycles without a beat, %0d headers owed",
				$time, quiet_cycles, pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offers one byte and holds it until the scanner takes it. The task is entered
	// and left at a falling edge. valid stays high when the next byte follows at
	// once, so it is never dropped and raised again within one time step.
	task automatic send_byte(input logic [7:0] b, input logic last);
		jmos_pkg::in_beat_t beat;
		beat.data_byte = b;
		beat.last_byte = last;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_if.valid <= 1'b0;
			@(negedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data <= beat;
		@(posedge clk);
		while (!byte_if.ready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends the bytes built up for one field, with last_byte on the final one.
	task automatic send_field();
		for (int i = 0; i < field_bytes.size(); i++)
			send_byte(field_bytes[i], i == field_bytes.size() - 1);
		fields_sent++;
	endtask

	// Waits until every owed header has been compared, then lets the pipeline run
	// empty, so that a register write cannot catch a byte in flight.
	task automatic drain();
		byte_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes both registers, one after the other, while the scanner is idle.
	task automatic write_modes(input logic raw, input logic report);
		cfg_we <= 1'b1;
		cfg_index <= jmos_pkg::CFG_RAW_LENGTH;
		cfg_data <= jmos_pkg::CFG_DATA_W'(raw);
		@(negedge clk);
		cfg_index <= jmos_pkg::CFG_REPORT_NEXT;
		cfg_data <= jmos_pkg::CFG_DATA_W'(report);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		mode_raw = raw;
	endtask

	function automatic void put(input logic [7:0] b);
		field_bytes.push_back(b);
	endfunction

	function automatic void put_random(input int n);
		repeat (n) put(8'($urandom_range(255)));
	endfunction

	// Number of bytes a segment body occupies for a given length word, so that
	// the generator keeps segments well formed under the current length mode.
	function automatic int body_bytes(input logic [7:0] m, input int len);
		if (m != jmos_pkg::MK_APP1 && mode_raw) return len;
		return (len >= 2) ? len - 2 : 0;
	endfunction

	// Mostly a small body; now and then a length from 0 to 3 to hit the short case.
	function automatic int pick_length(input logic [7:0] m);
		int body;
		if ($urandom_range(7) == 0) return $urandom_range(0, 3);
		body = $urandom_range(0, 6);
		return (m != jmos_pkg::MK_APP1 && mode_raw) ? body : body + 2;
	endfunction

	// A segment with a length word and a random body, sometimes after fill bytes.
	function automatic void put_segment(input logic [7:0] m, input int len);
		if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) put(jmos_pkg::MK_FF);
		put(jmos_pkg::MK_FF);
		put(m);
		put(8'(len >> 8));
		put(8'(len));
		put_random(body_bytes(m, len));
	endfunction

	// Any marker the scanner only passes over: SOI, restarts, APP0, COM and so on.
	function automatic logic [7:0] other_marker();
		logic [7:0] m;
		if ($urandom_range(3) == 0) return jmos_pkg::MK_SOI;
		do begin
			m = 8'($urandom_range(1, 254));
		end while (m == jmos_pkg::MK_DHT || m == jmos_pkg::MK_DQT ||
			m == jmos_pkg::MK_SOF0 || m == jmos_pkg::MK_SOS ||
			m == jmos_pkg::MK_EOI || m == jmos_pkg::MK_APP1);
		return m;
	endfunction

	// Builds one field: most are well-formed headers (SOI, table and frame segments,
	// APP1, SOS with entropy data and EOI) with random content; the rest carry loose
	// noise, stray markers, stuffed zeros, a bare EOI, or are cut short anywhere.
	function automatic void build_random_field();
		int kind;
		int len;
		int cut;
		field_bytes.delete();
		if ($urandom_range(3) != 0) begin
			put(jmos_pkg::MK_FF);
			put(jmos_pkg::MK_SOI);
		end
		repeat ($urandom_range(0, 3)) begin
			kind = $urandom_range(9);
			case (kind)
				0, 1: put_segment(jmos_pkg::MK_DQT, pick_length(jmos_pkg::MK_DQT));
				2, 3: put_segment(jmos_pkg::MK_DHT, pick_length(jmos_pkg::MK_DHT));
				4: put_segment(jmos_pkg::MK_SOF0, pick_length(jmos_pkg::MK_SOF0));
				5: put_segment(jmos_pkg::MK_APP1, pick_length(jmos_pkg::MK_APP1));
				6: begin
					put(jmos_pkg::MK_FF);
					put(other_marker());
					put_random($urandom_range(0, 3));
				end
				7: begin
					put(jmos_pkg::MK_FF);
					put(jmos_pkg::MK_STUFF);
					put_random($urandom_range(0, 3));
				end
				default: put_random($urandom_range(1, 6));
			endcase
		end
		kind = $urandom_range(9);
		if (kind <= 5) begin
			// The SOS length is never skipped, so any value is cheap; a full-range one
			// exercises the entropy offset arithmetic.
			len = ($urandom_range(4) == 0) ? $urandom_range(0, 65535) : $urandom_range(6, 12);
			put(jmos_pkg::MK_FF);
			put(jmos_pkg::MK_SOS);
			put(8'(len >> 8));
			put(8'(len));
			put_random($urandom_range(0, 6));
			repeat ($urandom_range(0, 8)) begin
				put(8'($urandom_range(255)));
				if (field_bytes[$] == jmos_pkg::MK_FF) put(jmos_pkg::MK_STUFF);
			end
			if ($urandom_range(1) != 0) begin
				put(jmos_pkg::MK_FF);
				put(jmos_pkg::MK_EOI);
			end
		end else if (kind <= 7) begin
			put(jmos_pkg::MK_FF);
			put(jmos_pkg::MK_EOI);
			put_random($urandom_range(0, 2));
		end
		if ($urandom_range(9) == 0 && field_bytes.size() > 1) begin
			cut = $urandom_range(1, field_bytes.size() - 1);
			while (field_bytes.size() > cut) void'(field_bytes.pop_back());
		end
		if (field_bytes.size() == 0) put(8'($urandom_range(255)));
	endfunction

	initial begin
		int seg_start;
		int seg_fields;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = jmos_pkg::CFG_RAW_LENGTH;
		cfg_data = '0;
		byte_if.valid = 1'b0;
		byte_if.data = '0;
		mode_raw = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed fields, with the registers at their reset values.
		// First: SOI, a fill byte before DHT whose one body byte is skipped, a stuffed
		// zero, DQT with a length below 2, APP1 with an empty body, then SOS; the two
		// bytes after the SOS length are ignored, the EOI code among them.
		field_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hC4, 8'h00, 8'h03, 8'h7F,
			8'hFF, 8'h00, 8'hFF, 8'hDB, 8'h00, 8'h01, 8'hFF, 8'hE1, 8'h00, 8'h02,
			8'hFF, 8'hDA, 8'h00, 8'h05, 8'h01, 8'hD9};
		send_field();
		// Second: SOF0 with a zero length, an unlisted marker, EOI, then an ignored byte.
		field_bytes = '{8'hFF, 8'hC0, 8'h00, 8'h00, 8'hFF, 8'h12, 8'hFF, 8'hD9, 8'h00};
		send_field();
		// Third: a field that ends inside the SOS length.
		field_bytes = '{8'hFF, 8'hDA, 8'h00};
		send_field();
		drain();

		// Random fields in eight segments: each idling phase runs twice, and the two
		// registers step through all four settings, each setting in two phases.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
				end
			endcase
			write_modes(seg[0], seg[1]);
			seg_start = bytes_sent;
			seg_fields = 0;
			if (seg == 1) begin
				// One DHT with a long raw length, so the skip counter runs down over
				// many consecutive bytes.
				field_bytes.delete();
				put_segment(jmos_pkg::MK_DHT, BIG_SKIP_LEN);
				put(jmos_pkg::MK_FF);
				put(jmos_pkg::MK_EOI);
				send_field();
			end
			while (bytes_sent - seg_start < SEG_MIN_BYTES || seg_fields < SEG_MIN_FIELDS) begin
				build_random_field();
				send_field();
				seg_fields++;
			end
			drain();
		end

		// Every header has been compared; give any stray beat time to show up.
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d fields and compared %0d header beats.",
			bytes_sent, fields_sent, headers_checked);
		$display("Covered four idling mixes, all four register settings and a %0d-byte skip.",
			BIG_SKIP_LEN);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== jpeg_marker_offset_scanner_top.f =====
rtl/core/jmos_pkg.sv
rtl/core/jmos_stream_if.sv
rtl/core/jpeg_marker_offset_scanner_top.sv
verif/jmos_offset_checker.sv
verif/tb_jpeg_marker_offset_scanner_top.sv
